// File: sv/masked_byte_pattern_scanner_macros.svh
// ----------------------------------------------------------------------------
// Masked byte pattern scanner assertion macros
// Shared assertion shorthands, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Widths, register indexes and payload types shared by the scanner modules.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN);
  localparam int ADDR_BITS   = 48;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_0      = 3'd0,
    CFG_PATTERN_1      = 3'd1,
    CFG_PATTERN_2      = 3'd2,
    CFG_PATTERN_3      = 3'd3,
    CFG_CARE_MASK      = 3'd4,
    CFG_PATTERN_LENGTH = 3'd5,
    CFG_BASE_ADDRESS   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] match_address;
  } out_item_t;

  // Signature set-up handed to the window comparator.
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] sig;
    logic [MAX_PATTERN-1:0]      care;
    logic [LEN_W-1:0]            len_m1;
  } pat_cfg_t;

endpackage

// File: sv/mbps_match.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner window comparator
// Compares the current byte and the held window against the signature.
// ----------------------------------------------------------------------------
module mbps_match
  import mbps_pkg::*;
(
  input  pat_cfg_t                   pat_cfg,
  input  logic [7:0]                 cur_byte,
  input  logic [WIN_DEPTH-1:0][7:0]  window,
  input  logic [LEN_W-1:0]           bytes_seen,
  output logic                       hit
);

  logic [MAX_PATTERN-1:0][7:0] seq;
  logic [MAX_PATTERN-1:0]      lane_ok;

  // Position 0 is the current byte, position i the byte i steps earlier.
  assign seq = {window, cur_byte};

  // Signature byte j lines up with the byte len_m1 - j steps back.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_lane
    logic [LEN_W-1:0] pos;
    logic             active;
    assign pos     = LEN_W'(pat_cfg.len_m1 - LEN_W'(j));
    assign active  = (LEN_W'(j) <= pat_cfg.len_m1);
    assign lane_ok[j] = !active || !pat_cfg.care[j] || (seq[pos] == pat_cfg.sig[j]);
  end

  assign hit = (bytes_seen >= pat_cfg.len_m1) && (&lane_ok);

endmodule

// File: sv/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Finds the first match of a masked byte signature in a streamed region.
// ----------------------------------------------------------------------------
// Usage: the bytes of a memory region arrive on the in_ channel, one byte per
// transaction, with last_byte set on the region's final byte. The block sends
// one transaction on the out_ channel per region: found=1 with the absolute
// start address of the first match as soon as that match completes, or
// found=0 with a zero address when the last byte passes without a match.
// Bytes after a match are absorbed silently up to the end of the region.
// Throughput is one byte per cycle unless a stalled result blocks the input
// register; a byte is held in the input register and its result is loaded
// into the output register when the byte moves on, raising out_valid. The
// depth is set by the input register and the output register around the
// window compare. A waiting result in the output register does not block
// the input register from being filled, so only a stall that lasts while the
// input register is also full pushes back onto in_stall.
// Reset (synchronous, rst_n low) clears the search, the handshake state and
// the configuration registers to their defaults (pattern length one, everything else zero).
// Configuration writes go through cfg_we, cfg_index and cfg_wdata. The user
// must make them only while no region is in progress; nothing enforces it.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scanner_macros.svh"

module masked_byte_pattern_scanner
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  // Configuration registers. The pattern length is kept as length minus one,
  // already clamped to the supported range.
  logic [3:0][CFG_DATA_W-1:0] pattern_r;
  logic [MAX_PATTERN-1:0]     care_r;
  logic [LEN_W-1:0]           len_m1_r;
  logic [ADDR_BITS-1:0]       base_r;
  logic [5:0]                 len_raw;
  logic [LEN_W-1:0]           len_m1_nxt;

  // Search state.
  logic [WIN_DEPTH-1:0][7:0]  window_r;
  logic [WIN_DEPTH-1:0][7:0]  window_nxt;
  logic [LEN_W-1:0]           seen_r;
  logic [LEN_W-1:0]           seen_nxt;
  logic [ADDR_BITS-1:0]       offset_r;
  logic [ADDR_BITS-1:0]       offset_nxt;
  logic                       reported_r;
  logic                       reported_nxt;

  // Input register and output register.
  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  in_item_t                   s1_item_r;
  logic                       s1_adv;
  logic                       in_accept;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  out_item_t                  out_item_r;
  out_item_t                  res_item;
  logic                       res_valid;

  pat_cfg_t                   pat_cfg;
  logic                       hit;
  logic                       first_hit;
  logic [ADDR_BITS-1:0]       start_offset;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign len_raw = cfg_wdata[5:0];

  // A zero length behaves as one, anything above the maximum as the maximum.
  always_comb begin
    if (len_raw == 6'd0) begin
      len_m1_nxt = '0;
    end else if (len_raw > 6'(MAX_PATTERN)) begin
      len_m1_nxt = LEN_W'(MAX_PATTERN - 1);
    end else begin
      len_m1_nxt = LEN_W'(len_raw - 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      care_r    <= '0;
      len_m1_r  <= '0;
      base_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_PATTERN_0:      pattern_r[0] <= cfg_wdata;
        CFG_PATTERN_1:      pattern_r[1] <= cfg_wdata;
        CFG_PATTERN_2:      pattern_r[2] <= cfg_wdata;
        CFG_PATTERN_3:      pattern_r[3] <= cfg_wdata;
        CFG_CARE_MASK:      care_r       <= cfg_wdata[MAX_PATTERN-1:0];
        CFG_PATTERN_LENGTH: len_m1_r     <= len_m1_nxt;
        CFG_BASE_ADDRESS:   base_r       <= cfg_wdata[ADDR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  // The held byte moves on whenever the output register is free or is being
  // emptied in this cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
  end

  // ---------------------------------------------------------------------------
  // Window compare
  // ---------------------------------------------------------------------------
  assign pat_cfg.sig    = pattern_r;
  assign pat_cfg.care   = care_r;
  assign pat_cfg.len_m1 = len_m1_r;

  mbps_match u_match (
    .pat_cfg    (pat_cfg),
    .cur_byte   (s1_item_r.data_byte),
    .window     (window_r),
    .bytes_seen (seen_r),
    .hit        (hit)
  );

  assign first_hit    = hit && !reported_r;
  assign start_offset = offset_r - ADDR_BITS'(len_m1_r);

  // A result leaves on the first match, or at the region's end when nothing
  // has been reported yet.
  always_comb begin
    res_valid              = first_hit || (s1_item_r.last_byte && !reported_r);
    res_item.found         = first_hit;
    res_item.match_address = first_hit ? (base_r + start_offset) : '0;
  end

  // ---------------------------------------------------------------------------
  // Search state update
  // ---------------------------------------------------------------------------
  // The window needs no clearing: bytes older than the region are never read,
  // because the byte count gates the compare.
  always_comb begin
    window_nxt    = {window_r[WIN_DEPTH-2:0], s1_item_r.data_byte};
    seen_nxt      = (seen_r == LEN_W'(WIN_DEPTH)) ? seen_r : LEN_W'(seen_r + 1'b1);
    offset_nxt    = (&offset_r) ? offset_r : ADDR_BITS'(offset_r + 1'b1);
    reported_nxt  = reported_r || first_hit;
    if (s1_item_r.last_byte) begin
      seen_nxt     = '0;
      offset_nxt   = '0;
      reported_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      offset_r   <= '0;
      reported_r <= 1'b0;
    end else if (s1_adv) begin
      seen_r     <= seen_nxt;
      offset_r   <= offset_nxt;
      reported_r <= reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      window_r <= window_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MBPS_ASSERT(a_nomatch_zero_addr,
    (out_valid_r && !out_item_r.found) |-> (out_item_r.match_address == '0),
    "end-of-region result carries a non-zero address")
  `MBPS_ASSERT_NEXT(a_last_clears, s1_adv && s1_item_r.last_byte,
    (seen_r == '0) && (offset_r == '0) && !reported_r,
    "search not cleared after the region's last byte")
  `MBPS_ASSERT_NEXT(a_held_byte_kept, s1_valid_r && !s1_adv,
    s1_valid_r && $stable(s1_item_r),
    "held byte lost while the output was blocked")
  `MBPS_ASSERT(a_single_report,
    (s1_adv && reported_r) |-> !(res_valid && res_item.found),
    "second match reported in one region")

endmodule
